@@ hdl/sparse_matrix_add_merge_top_defines.svh @@
// ----------------------------------------------------------------------------
// Sparse matrix add merge: assertion macros
// Shared property wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_ADD_MERGE_TOP_DEFINES_SVH
`define SPARSE_MATRIX_ADD_MERGE_TOP_DEFINES_SVH

// Same-cycle implication.
`define SMA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define SMA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/sma_pkg.sv @@
// ----------------------------------------------------------------------------
// Sparse matrix add merge package
// Transaction types, field widths and opcodes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

  localparam int unsigned MaxTermsDef = 32;
  localparam int unsigned MaxDimDef   = 1024;

  localparam int unsigned CoordW = 10;
  localparam int unsigned KeyW   = 2 * CoordW;
  localparam int unsigned ExtW   = CoordW + 1;
  localparam int unsigned ValueW = 32;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [CoordW-1:0]        entry_row;
    logic [CoordW-1:0]        entry_col;
    logic signed [ValueW-1:0] entry_value;
  } sma_in_t;

  typedef struct packed {
    logic [CoordW-1:0]        sum_row;
    logic [CoordW-1:0]        sum_col;
    logic signed [ValueW-1:0] sum_value;
    logic                     has_entry;
    logic                     size_error;
    logic                     last;
  } sma_out_t;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } sma_entry_t;

  typedef struct packed {
    logic [ExtW-1:0] rows;
    logic [ExtW-1:0] cols;
  } sma_extent_t;

endpackage

`default_nettype wire

@@ hdl/sma_store.sv @@
// ----------------------------------------------------------------------------
// Sparse matrix store
// Entry memory with registered read, fill count, last key and extent tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sma_store #(
  parameter int unsigned MAX_TERMS = sma_pkg::MaxTermsDef,
  parameter int unsigned MAX_DIM   = sma_pkg::MaxDimDef,
  localparam int unsigned IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int unsigned CntW = $clog2(MAX_TERMS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic                      clear_i,
  input  logic [sma_pkg::CoordW-1:0] row_i,
  input  logic [sma_pkg::CoordW-1:0] col_i,
  input  logic [sma_pkg::ValueW-1:0] value_i,
  input  logic [IdxW-1:0]           rd_addr_i,
  output sma_pkg::sma_entry_t       rd_data_o,
  output logic [CntW-1:0]           cnt_o,
  output sma_pkg::sma_extent_t      extent_o
);
  import sma_pkg::*;

  sma_entry_t        mem_q [MAX_TERMS];
  sma_entry_t        rd_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [KeyW-1:0]   last_q, last_d;
  sma_extent_t       ext_q, ext_d;
  logic [KeyW-1:0]   key;
  logic [ExtW-1:0]   row_p1, col_p1;
  logic              in_range, not_full, in_order, wr_en;

  assign key      = {row_i, col_i};
  assign row_p1   = {1'b0, row_i} + ExtW'(1);
  assign col_p1   = {1'b0, col_i} + ExtW'(1);
  assign in_range = ({1'b0, row_i} < ExtW'(MAX_DIM)) && ({1'b0, col_i} < ExtW'(MAX_DIM));
  assign not_full = cnt_q != CntW'(MAX_TERMS);
  assign in_order = (cnt_q == '0) || (key > last_q);
  assign wr_en    = load_i && in_range && not_full && in_order;

  always_comb begin
    cnt_d  = cnt_q;
    last_d = last_q;
    ext_d  = ext_q;
    if (clear_i) begin
      cnt_d = '0;
      ext_d = '0;
    end else if (wr_en) begin
      cnt_d  = cnt_q + CntW'(1);
      last_d = key;
      if (ext_q.rows < row_p1) begin
        ext_d.rows = row_p1;
      end
      if (ext_q.cols < col_p1) begin
        ext_d.cols = col_p1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= '0;
      ext_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
      ext_q  <= ext_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[IdxW-1:0]] <= '{key: key, value: value_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign cnt_o     = cnt_q;
  assign extent_o  = ext_q;

endmodule

`default_nettype wire

@@ hdl/sparse_matrix_add_merge_top.sv @@
// Load transactions produce no result. On a size mismatch a run emits only
// an error result; otherwise the merge takes one step per distinct coordinate
// in A and B, up to 2*MAX_TERMS; each step reads both entry memories once and
// emits at most one result, so results leave at most one per cycle.
// Output backpressure stalls the merge. Reset clears counts, extents and control;
// the entry memories are not cleared.
// ----------------------------------------------------------------------------
// Sparse matrix add merge top
// Two coordinate-list stores and a row-major merge that emits the sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_matrix_add_merge_top #(
  parameter int unsigned MAX_TERMS = sma_pkg::MaxTermsDef,
  parameter int unsigned MAX_DIM   = sma_pkg::MaxDimDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sma_pkg::sma_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sma_pkg::sma_out_t out_data_o
);
  import sma_pkg::*;

  localparam int unsigned IdxW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TERMS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_FLUSH
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  sma_entry_t      pend_q, pend_d;
  logic            pend_valid_q, pend_valid_d;
  logic            err_q, err_d;
  sma_out_t        out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            load_a, load_b, clear;
  sma_entry_t      a_rd, b_rd;
  logic [CntW-1:0] a_cnt, b_cnt;
  sma_extent_t     a_ext, b_ext;

  logic              a_has, b_has, take_a, take_b, done, out_free;
  logic [KeyW-1:0]   cand_key;
  logic [ValueW-1:0] cand_val;

  sma_store #(.MAX_TERMS(MAX_TERMS), .MAX_DIM(MAX_DIM)) u_store_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load_a),
    .clear_i   (clear),
    .row_i     (in_data_i.entry_row),
    .col_i     (in_data_i.entry_col),
    .value_i   (in_data_i.entry_value),
    .rd_addr_i (a_idx_d[IdxW-1:0]),
    .rd_data_o (a_rd),
    .cnt_o     (a_cnt),
    .extent_o  (a_ext)
  );

  sma_store #(.MAX_TERMS(MAX_TERMS), .MAX_DIM(MAX_DIM)) u_store_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load_b),
    .clear_i   (clear),
    .row_i     (in_data_i.entry_row),
    .col_i     (in_data_i.entry_col),
    .value_i   (in_data_i.entry_value),
    .rd_addr_i (b_idx_d[IdxW-1:0]),
    .rd_data_o (b_rd),
    .cnt_o     (b_cnt),
    .extent_o  (b_ext)
  );

  assign a_has    = a_idx_q < a_cnt;
  assign b_has    = b_idx_q < b_cnt;
  assign take_a   = a_has && (!b_has || (a_rd.key < b_rd.key));
  assign take_b   = b_has && (!a_has || (b_rd.key < a_rd.key));
  assign done     = !a_has && !b_has;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (take_a) begin
      cand_key = a_rd.key;
      cand_val = a_rd.value;
    end else if (take_b) begin
      cand_key = b_rd.key;
      cand_val = b_rd.value;
    end else begin
      cand_key = a_rd.key;
      cand_val = a_rd.value + b_rd.value;
    end
  end

  always_comb begin
    state_d      = state_q;
    a_idx_d      = a_idx_q;
    b_idx_d      = b_idx_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    err_d        = err_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    load_a       = 1'b0;
    load_b       = 1'b0;
    clear        = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        a_idx_d = '0;
        b_idx_d = '0;
        if (in_valid_i) begin
          case (in_data_i.opcode)
            OP_LOAD_A: load_a = 1'b1;
            OP_LOAD_B: load_b = 1'b1;
            OP_RUN: begin
              pend_valid_d = 1'b0;
              if (a_ext != b_ext) begin
                err_d   = 1'b1;
                state_d = ST_FLUSH;
              end else begin
                state_d = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (done) begin
          state_d = ST_FLUSH;
        end else if (out_free || !pend_valid_q) begin
          if (take_a || !take_b) begin
            a_idx_d = a_idx_q + CntW'(1);
          end
          if (take_b || !take_a) begin
            b_idx_d = b_idx_q + CntW'(1);
          end
          if (cand_val != '0) begin
            pend_d       = '{key: cand_key, value: cand_val};
            pend_valid_d = 1'b1;
            if (pend_valid_q) begin
              out_d       = '{sum_row: pend_q.key[KeyW-1:CoordW],
                              sum_col: pend_q.key[CoordW-1:0],
                              sum_value: pend_q.value,
                              has_entry: 1'b1, size_error: 1'b0, last: 1'b0};
              out_valid_d = 1'b1;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_valid_q) begin
            out_d = '{sum_row: pend_q.key[KeyW-1:CoordW],
                      sum_col: pend_q.key[CoordW-1:0],
                      sum_value: pend_q.value,
                      has_entry: 1'b1, size_error: 1'b0, last: 1'b1};
          end else begin
            out_d = '{sum_row: '0, sum_col: '0, sum_value: '0,
                      has_entry: 1'b0, size_error: err_q, last: 1'b1};
          end
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          err_d        = 1'b0;
          clear        = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      a_idx_q      <= '0;
      b_idx_q      <= '0;
      pend_valid_q <= 1'b0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      a_idx_q      <= a_idx_d;
      b_idx_q      <= b_idx_d;
      pend_valid_q <= pend_valid_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ hdl/sma_checker.sv @@
// ----------------------------------------------------------------------------
// Sparse matrix add merge checker
// Port-level properties of result transactions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sparse_matrix_add_merge_top_defines.svh"

module sma_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire sma_pkg::sma_in_t  in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire sma_pkg::sma_out_t out_data_o
);
  import sma_pkg::*;

  `SMA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_data_o), "result changed while stalled")

  `SMA_ASSERT_NOW(a_err_form, out_valid_o && out_data_o.size_error,
                  out_data_o.last && !out_data_o.has_entry && out_data_o.sum_value == '0,
                  "size error result malformed")

  `SMA_ASSERT_NOW(a_entry_nonzero, out_valid_o && out_data_o.has_entry,
                  out_data_o.sum_value != '0 && !out_data_o.size_error,
                  "entry result with zero value or error")

  `SMA_ASSERT_NOW(a_empty_last, out_valid_o && !out_data_o.has_entry,
                  out_data_o.last && out_data_o.sum_row == '0 && out_data_o.sum_col == '0,
                  "empty result not final")

endmodule

bind sparse_matrix_add_merge_top sma_checker u_sma_checker (.*);

`default_nettype wire
